/* design/sapg_pkg.sv */
// ----------------------------------------------------------------------------
// sapg_pkg
// Shared widths, command codes and constants of the stepper ramp generator.
// ----------------------------------------------------------------------------
package sapg_pkg;

	// command codes on the mode field
	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_ABS  = 3'd1;
	localparam logic [2:0] MODE_REL  = 3'd2;
	localparam logic [2:0] MODE_SET  = 3'd3;
	localparam logic [2:0] MODE_STOP = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_ACCEL = 3'd0;
	localparam logic [2:0] REG_FIRST = 3'd1;
	localparam logic [2:0] REG_MIN   = 3'd2;
	localparam logic [2:0] REG_PULSE = 3'd3;
	localparam logic [2:0] REG_DINV  = 3'd4;

	// divider width: covers 2^15*1e12 and interval squared
	localparam int DIV_W = 57;
	localparam int CNT_W = 6;
	localparam logic [DIV_W-1:0] STOP_NUM = 57'd32768000000000000;
	localparam logic [39:0] C_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [32:0] DIR_LEAD = 33'd10;

	typedef logic [DIV_W-1:0] div_word_t;

endpackage

/* design/sapg_if.sv */
// ----------------------------------------------------------------------------
// sapg_in_if / sapg_out_if
// Valid/ready channels for commands in and pin status results out.
// ----------------------------------------------------------------------------
interface sapg_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] value;
	modport source (output valid, mode, value, input ready);
	modport sink   (input valid, mode, value, output ready);
endinterface

interface sapg_out_if;
	logic               valid;
	logic               ready;
	logic               step_level;
	logic               dir_level;
	logic               stepped;
	logic signed [31:0] position;
	logic               busy_res;
	modport source (output valid, step_level, dir_level, stepped, position, busy_res,
		input ready);
	modport sink   (input valid, step_level, dir_level, stepped, position, busy_res,
		output ready);
endinterface

/* design/stepper_accel_profile_generator_core.sv */
// ----------------------------------------------------------------------------
// stepper_accel_profile_generator_core
// Step/direction generator with a trapezoidal ramp, one command or tick a beat.
// ----------------------------------------------------------------------------
// One item is handled at a time and answered with exactly one result beat.
// A tick that issues no step, set position, an unchanged move, a stop while
// stopped and an unused mode go from accept straight to the result beat. A
// step, a changed move or a stop while running runs the ramp update on one
// shared restoring divider that retires one quotient bit per cycle over 57
// bits: stop-distance needs two divisions and the interval update one. The
// stop-distance divisions are skipped when the motor is stopped or the
// interval is long. The input is not ready until the result beat is taken.
module stepper_accel_profile_generator_core
	import sapg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sapg_in_if.sink     in_ch,
	sapg_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SS   = 4'd1;
	localparam logic [3:0] S_D1ST = 4'd2;
	localparam logic [3:0] S_D1   = 4'd3;
	localparam logic [3:0] S_D2   = 4'd4;
	localparam logic [3:0] S_RET  = 4'd5;
	localparam logic [3:0] S_DEC  = 4'd6;
	localparam logic [3:0] S_D3   = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	// configuration
	logic [19:0] accel_q;
	logic [31:0] first_q, min_q;
	logic [15:0] pw_q;
	logic        dinv_q;

	// motion state
	logic [3:0]         state_q;
	logic [31:0]        cur_q, tgt_q;
	logic signed [31:0] n_q;
	logic [39:0]        frac_q;
	logic               run_q;
	logic [31:0]        el_q;
	logic               dnow_q, dnext_q, pulse_q, sneg_q;
	logic               stepped_q, stopcmd_q;
	logic [30:0]        steps_q;
	logic [DIV_W-1:0]   sq_q;

	// divider
	div_word_t          dq_q, dd_q;
	logic [DIV_W:0]     dr_q;
	logic [CNT_W-1:0]   dc_q;
	logic               dstart;
	div_word_t          dstart_num, dstart_den;

	// effective (nonzero) configuration values
	logic [19:0] accel_e;
	logic [31:0] first_e, min_e;
	assign accel_e = (accel_q == '0) ? 20'd1 : accel_q;
	assign first_e = (first_q == '0) ? 32'd1 : first_q;
	assign min_e   = (min_q == '0) ? 32'd1 : min_q;

	logic [31:0] period;
	assign period = run_q ? frac_q[39:8] : 32'd0;

	// tick evaluation
	logic [31:0] el_n;
	logic        tk_dir, tk_clr, tk_step;
	always_comb begin
		el_n   = (el_q == 32'hFFFF_FFFF) ? el_q : el_q + 32'd1;
		tk_dir = 1'b0;
		tk_clr = 1'b0;
		tk_step = 1'b0;
		if (!run_q) begin
			tk_clr = pulse_q && (el_n >= {16'd0, pw_q});
		end else if ((dnext_q != dnow_q) && ({1'b0, el_n} + DIR_LEAD >= {1'b0, period})) begin
			tk_dir = 1'b1;
		end else if (pulse_q) begin
			tk_clr = el_n >= {16'd0, pw_q};
		end else if (el_n >= period) begin
			tk_step = 1'b1;
		end
	end

	// stop distance operand
	logic [28:0] ss_c;
	logic        ss_zero;
	assign ss_zero = !run_q || (frac_q > 40'h1000_0000);
	assign ss_c    = (frac_q < 40'd256) ? 29'd256 : frac_q[28:0];

	// stop command target
	logic [31:0] stop_s, stop_abs;
	assign stop_s   = {1'b0, steps_q} + 32'd1;
	assign stop_abs = sneg_q ? cur_q - stop_s : cur_q + stop_s;

	// ramp decision
	logic signed [32:0] span;
	logic [32:0]        dmag;
	logic               dpos, dneg, dge;
	logic signed [31:0] n_new, neg_steps;
	logic [33:0]        den_raw, den_mag;
	always_comb begin
		span = $signed({tgt_q[31], tgt_q}) - $signed({cur_q[31], cur_q});
		dpos = !span[32] && (span != '0);
		dneg = span[32];
		dmag = dneg ? 33'(-span) : 33'(span);
		dge  = {2'b0, steps_q} >= dmag;
		neg_steps = -$signed({1'b0, steps_q});
		n_new = n_q;
		if (dpos) begin
			if (n_q > 0) begin
				if (dge || !dnow_q) n_new = neg_steps;
			end else if (n_q < 0) begin
				if (!dge && dnow_q) n_new = -n_q;
			end
		end else if (dneg) begin
			if (n_q > 0) begin
				if (dge || dnow_q) n_new = neg_steps;
			end else if (n_q < 0) begin
				if (!dge && !dnow_q) n_new = -n_q;
			end
		end
		den_raw = {n_new, 2'b01};
		den_mag = den_raw[33] ? ~den_raw + 34'd1 : den_raw;
	end

	// interval finish after the ramp division
	logic [40:0] c_sub;
	logic [41:0] c_add;
	logic [39:0] c_new, c_min;
	always_comb begin
		c_sub = {1'b0, frac_q} - dq_q[40:0];
		c_add = {2'b0, frac_q} + dq_q[41:0];
		c_min = {min_e, 8'd0};
		if (n_q > 0) c_new = c_sub[39:0];
		else c_new = (c_add > {2'b0, C_MAX}) ? C_MAX : c_add[39:0];
		if (c_new < c_min) c_new = c_min;
	end

	logic [31:0] move_abs;
	assign move_abs = (in_ch.mode == MODE_ABS) ? in_ch.value : cur_q + in_ch.value;

	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	// divider start control
	always_comb begin
		dstart = 1'b0;
		dstart_num = STOP_NUM;
		dstart_den = sq_q;
		unique case (state_q)
			S_D1ST: dstart = 1'b1;
			S_D1: begin
				dstart = (dc_q == '0);
				dstart_num = dq_q;
				dstart_den = {37'd0, accel_e};
			end
			S_DEC: begin
				dstart = !(span == '0 && steps_q <= 31'd1) && (n_new != 0);
				dstart_num = {16'd0, frac_q, 1'b0};
				dstart_den = {23'd0, den_mag};
			end
			default: dstart = 1'b0;
		endcase
	end

	// shared restoring divider, one quotient bit a cycle
	logic [DIV_W:0] dshift;
	logic           dbit;
	assign dshift = {dr_q[DIV_W-1:0], dq_q[DIV_W-1]};
	assign dbit   = dshift >= {1'b0, dd_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
		end else if (dstart) begin
			dc_q <= CNT_W'(DIV_W);
		end else if (dc_q != '0) begin
			dc_q <= dc_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (dstart) begin
			dq_q <= dstart_num;
			dd_q <= dstart_den;
			dr_q <= '0;
		end else if (dc_q != '0) begin
			dr_q <= dbit ? dshift - {1'b0, dd_q} : dshift;
			dq_q <= {dq_q[DIV_W-2:0], dbit};
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= 20'd1;
			first_q <= 32'd956008;
			min_q   <= 32'd1000000;
			pw_q    <= 16'd5;
			dinv_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEL: accel_q <= cfg_wdata[19:0];
				REG_FIRST: first_q <= cfg_wdata;
				REG_MIN:   min_q   <= cfg_wdata;
				REG_PULSE: pw_q    <= cfg_wdata[15:0];
				REG_DINV:  dinv_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			tgt_q     <= '0;
			n_q       <= '0;
			frac_q    <= '0;
			run_q     <= 1'b0;
			el_q      <= '0;
			dnow_q    <= 1'b0;
			dnext_q   <= 1'b0;
			pulse_q   <= 1'b0;
			sneg_q    <= 1'b0;
			stepped_q <= 1'b0;
			stopcmd_q <= 1'b0;
			steps_q   <= '0;
			sq_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					stepped_q <= 1'b0;
					stopcmd_q <= 1'b0;
					state_q   <= S_OUT;
					unique case (in_ch.mode)
						MODE_TICK: begin
							el_q <= el_n;
							if (tk_dir) dnow_q <= dnext_q;
							if (tk_clr) pulse_q <= 1'b0;
							if (tk_step) begin
								cur_q     <= dnow_q ? cur_q + 32'd1 : cur_q - 32'd1;
								pulse_q   <= 1'b1;
								el_q      <= '0;
								stepped_q <= 1'b1;
								state_q   <= S_SS;
							end
						end
						MODE_ABS, MODE_REL: if (tgt_q != move_abs) begin
							tgt_q   <= move_abs;
							state_q <= S_SS;
						end
						MODE_SET: begin
							cur_q  <= in_ch.value;
							tgt_q  <= in_ch.value;
							n_q    <= '0;
							run_q  <= 1'b0;
							sneg_q <= 1'b0;
						end
						MODE_STOP: if (run_q) begin
							stopcmd_q <= 1'b1;
							state_q   <= S_SS;
						end
						default: ;
					endcase
				end
				S_SS: begin
					if (ss_zero) begin
						steps_q <= '0;
						state_q <= S_RET;
					end else begin
						sq_q    <= DIV_W'(ss_c * ss_c);
						state_q <= S_D1ST;
					end
				end
				S_D1ST: state_q <= S_D1;
				S_D1: if (dc_q == '0) state_q <= S_D2;
				S_D2: if (dc_q == '0) begin
					steps_q <= (dq_q > {26'd0, 31'h7FFF_FFFF}) ? 31'h7FFF_FFFF : dq_q[30:0];
					state_q <= S_RET;
				end
				S_RET: begin
					if (!stopcmd_q) begin
						state_q <= S_DEC;
					end else if (tgt_q != stop_abs) begin
						tgt_q   <= stop_abs;
						state_q <= S_DEC;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DEC: begin
					if (span == '0 && steps_q <= 31'd1) begin
						run_q   <= 1'b0;
						n_q     <= '0;
						sneg_q  <= 1'b0;
						state_q <= S_OUT;
					end else if (n_new == 0) begin
						frac_q  <= {first_e, 8'd0};
						dnext_q <= dpos;
						n_q     <= 32'sd1;
						run_q   <= 1'b1;
						sneg_q  <= !dnow_q;
						state_q <= S_OUT;
					end else begin
						n_q     <= n_new;
						state_q <= S_D3;
					end
				end
				S_D3: if (dc_q == '0) begin
					frac_q  <= c_new;
					if (n_q != 32'sh7FFF_FFFF) n_q <= n_q + 32'sd1;
					run_q   <= 1'b1;
					sneg_q  <= !dnow_q;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ports
	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = (state_q == S_OUT);
	assign out_ch.step_level = pulse_q;
	assign out_ch.dir_level  = dnow_q ^ dinv_q;
	assign out_ch.stepped    = stepped_q;
	assign out_ch.position   = cur_q;
	assign out_ch.busy_res   = run_q || (tgt_q != cur_q) || pulse_q;

	// a running motor always has a nonzero step period
	a_run_period: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (frac_q[39:8] != '0)) else $error("running with zero period");

	// a step beat always shows the pulse high
	a_step_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && stepped_q) |-> pulse_q) else $error("step without pulse");

	// divider only counts inside its division states
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		(dc_q != '0) |-> (state_q == S_D1 || state_q == S_D2 || state_q == S_D3))
		else $error("divider busy outside division");

	// a finished result beat returns to idle
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready) |=> in_ch.ready) else $error("no return to idle");

endmodule

/* sim/sapg_tb_if.sv */
// ----------------------------------------------------------------------------
// sapg testbench channels
// Testbench timescale; the testbench uses the design's command and pin status channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

/* sim/stepper_accel_profile_generator_core_tb.sv */
// ----------------------------------------------------------------------------
// stepper_accel_profile_generator_core_tb
// Drives ticks and motion commands through the ramp generator under random
// handshake gaps, predicts every status beat and compares it with the received beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stepper_accel_profile_generator_core_tb;
	import sapg_pkg::*;

	typedef struct packed {
		logic               step_level;
		logic               dir_level;
		logic               stepped;
		logic signed [31:0] position;
		logic               busy_res;
	} pin_status_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	sapg_in_if  cmd_ch ();
	sapg_out_if pin_ch ();

	stepper_accel_profile_generator_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(cmd_ch.sink), .out_ch(pin_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// motor model state
	logic [19:0] m_accel;
	logic [31:0] m_first, m_min, m_pulse_w;
	logic        m_dinv;
	logic [31:0] m_pos, m_target, m_period, m_elapsed;
	longint      m_index;
	logic [63:0] m_cn;
	logic        m_dir, m_dir_next, m_pulse, m_speed_neg;

	pin_status_t status_q[$];
	int          mismatches;
	int          beats_seen;
	int          steps_seen;
	longint      cycle_count;
	bit          sink_hold;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// timeout guard
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 4000000) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic logic [63:0] nz(logic [63:0] x);
		return (x == 0) ? 64'd1 : x;
	endfunction

	function automatic longint as_signed32(logic [31:0] x);
		return longint'($signed(x));
	endfunction

	function automatic longint steps_to_stop();
		logic [63:0] c, q;
		if (m_period == 0 || m_cn > (64'd1 << 28))
			return 0;
		c = (m_cn < 64'd256) ? 64'd256 : m_cn;
		q = (64'd32768000000000000 / (c * c)) / nz(m_accel);
		if (q > 64'd2147483647)
			q = 64'd2147483647;
		return longint'(q);
	endfunction

	// interval update after a step, a changed move or a stop
	function automatic void ramp_update();
		longint      span, steps, den;
		logic [63:0] c, q, cmin;
		span = as_signed32(m_target) - as_signed32(m_pos);
		steps = steps_to_stop();
		if (span == 0 && steps <= 1) begin
			m_period = 0;
			m_index = 0;
			m_speed_neg = 1'b0;
			return;
		end
		if (span > 0) begin
			if (m_index > 0) begin
				if (steps >= span || !m_dir) m_index = -steps;
			end else if (m_index < 0) begin
				if (steps < span && m_dir) m_index = -m_index;
			end
		end else if (span < 0) begin
			if (m_index > 0) begin
				if (steps >= -span || m_dir) m_index = -steps;
			end else if (m_index < 0) begin
				if (steps < -span && !m_dir) m_index = -m_index;
			end
		end
		if (m_index == 0) begin
			c = nz(m_first) << 8;
			m_dir_next = (span > 0);
		end else begin
			den = 4 * m_index + 1;
			c = m_cn;
			q = (2 * c) / 64'(den < 0 ? -den : den);
			if (den > 0)
				c = c - q;
			else
				c = (c + q > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : c + q;
			cmin = nz(m_min) << 8;
			if (c < cmin)
				c = cmin;
		end
		if (m_index < 2147483647)
			m_index++;
		m_cn = c;
		m_period = c[39:8];
		m_speed_neg = !m_dir;
	endfunction

	function automatic void seek(logic [31:0] p);
		if (m_target != p) begin
			m_target = p;
			ramp_update();
		end
	endfunction

	function automatic pin_status_t predict_status(logic [2:0] mode, logic [31:0] val);
		pin_status_t r;
		logic        st;
		logic [31:0] s;
		st = 1'b0;
		case (mode)
			MODE_TICK: begin
				if (m_elapsed != 32'hFFFF_FFFF)
					m_elapsed++;
				if (m_period == 0) begin
					if (m_pulse && m_elapsed >= m_pulse_w) m_pulse = 1'b0;
				end else if (m_dir_next != m_dir &&
						(64'(m_elapsed) + 64'd10 >= 64'(m_period))) begin
					m_dir = m_dir_next;
				end else if (m_pulse) begin
					if (m_elapsed >= m_pulse_w) m_pulse = 1'b0;
				end else if (m_elapsed >= m_period) begin
					m_pos = m_dir ? m_pos + 1 : m_pos - 1;
					m_pulse = 1'b1;
					m_elapsed = 0;
					st = 1'b1;
					ramp_update();
				end
			end
			MODE_ABS: seek(val);
			MODE_REL: seek(m_pos + val);
			MODE_SET: begin
				m_pos = val;
				m_target = val;
				m_index = 0;
				m_period = 0;
				m_speed_neg = 1'b0;
			end
			MODE_STOP: begin
				if (m_period != 0) begin
					s = 32'(steps_to_stop() + 1);
					seek(m_speed_neg ? m_pos - s : m_pos + s);
				end
			end
			default: ;
		endcase
		r.step_level = m_pulse;
		r.dir_level  = m_dir ^ m_dinv;
		r.stepped    = st;
		r.position   = m_pos;
		r.busy_res   = (m_period != 0 || m_target != m_pos || m_pulse);
		return r;
	endfunction

	// result sink: random stalls, compare each beat with the oldest prediction
	initial begin
		pin_status_t exp_s, got;
		int          gap;
		pin_ch.ready <= 1'b0;
		sink_hold = 0;
		@(posedge arst_n);
		forever begin
			gap = sink_hold ? 0 : $urandom_range(0, 10);
			if (gap != 0) begin
				pin_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pin_ch.ready <= 1'b1;
			@(posedge clk);
			while (!pin_ch.valid) @(posedge clk);
			got = '{pin_ch.step_level, pin_ch.dir_level, pin_ch.stepped,
				pin_ch.position, pin_ch.busy_res};
			beats_seen++;
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %p", got);
			end else begin
				exp_s = status_q.pop_front();
				if (got.stepped) steps_seen++;
				if (got !== exp_s) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: expected %p got %p", beats_seen, exp_s, got);
				end
			end
		end
	end

	// one command or tick beat, with a random lead gap
	task automatic send_item(logic [2:0] mode, logic [31:0] val, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode  <= mode;
		cmd_ch.value <= val;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		status_q.push_back(predict_status(mode, val));
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_ACCEL: m_accel = data[19:0];
			REG_FIRST: m_first = data;
			REG_MIN:   m_min = data;
			REG_PULSE: m_pulse_w = {16'd0, data[15:0]};
			REG_DINV:  m_dinv = data[0];
			default: ;
		endcase
	endtask

	task automatic set_profile(logic [19:0] acc, logic [31:0] first, logic [31:0] minv,
			logic [15:0] pw, logic dinv);
		drain();
		write_reg(REG_ACCEL, {12'd0, acc});
		write_reg(REG_FIRST, first);
		write_reg(REG_MIN, minv);
		write_reg(REG_PULSE, {16'd0, pw});
		write_reg(REG_DINV, {31'd0, dinv});
		cfg_we <= 1'b0;
	endtask

	task automatic ticks(int n);
		repeat (n) send_item(MODE_TICK, $urandom);
	endtask

	// directed: field extremes, each command, unused modes
	task automatic test_directed();
		send_item(MODE_TICK, 32'h0);
		send_item(MODE_STOP, 32'hFFFF_FFFF);
		send_item(3'd5, 32'h8000_0000);
		send_item(3'd6, 32'h7FFF_FFFF);
		send_item(3'd7, 32'h5555_5555);
		set_profile(20'd0, 32'd0, 32'd0, 16'd0, 1'b1);
		send_item(MODE_ABS, 32'd3);
		ticks(6);
		send_item(MODE_SET, 32'h7FFF_FFFF);
		send_item(MODE_REL, 32'd2);
		ticks(4);
		send_item(MODE_SET, 32'h8000_0000);
		send_item(MODE_ABS, 32'h7FFF_FFFF);
		ticks(3);
		send_item(MODE_STOP, 32'd0);
		ticks(4);
		send_item(MODE_ABS, 32'h0);
	endtask

	// random ramp moves under a given profile: accelerate, cruise, reverse, stop
	task automatic test_ramps(logic [19:0] acc, logic [31:0] first, logic [31:0] minv,
			logic [15:0] pw, logic dinv, int items);
		int     sent;
		int     r;
		set_profile(acc, first, minv, pw, dinv);
		send_item(MODE_SET, $urandom);
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(0, 99);
			if (r < 80) send_item(MODE_TICK, $urandom);
			else if (r < 87) send_item(MODE_REL, $signed($urandom_range(0, 60)) - 30);
			else if (r < 91) send_item(MODE_ABS, m_pos + $urandom_range(0, 40) - 20);
			else if (r < 94) send_item(MODE_STOP, $urandom);
			else if (r < 96) send_item(MODE_SET, $urandom);
			else if (r < 98) send_item(MODE_REL, $urandom);
			else send_item(3'($urandom_range(5, 7)), $urandom);
			sent++;
		end
	endtask

	// back-to-back ticks with no gaps
	task automatic test_burst();
		send_item(MODE_REL, 32'd12);
		repeat (80) send_item(MODE_TICK, $urandom, 1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_TICK;
		cmd_ch.value = '0;
		mismatches = 0;
		beats_seen = 0;
		steps_seen = 0;
		m_accel = 20'd1; m_first = 32'd956008; m_min = 32'd1000000;
		m_pulse_w = 32'd5; m_dinv = 1'b0;
		m_pos = 0; m_target = 0; m_period = 0; m_elapsed = 0; m_index = 0;
		m_cn = 0; m_dir = 0; m_dir_next = 0; m_pulse = 0; m_speed_neg = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_ramps(20'd1000000, 32'd12, 32'd2, 16'd1, 1'b0, 300);
		test_ramps(20'd50000, 32'd20, 32'd3, 16'd3, 1'b1, 300);
		test_burst();
		test_ramps(20'd1000000, 32'd30, 32'd1, 16'd0, 1'b0, 250);
		test_ramps(20'd1000, 32'd8, 32'd4, 16'd65535, 1'b1, 150);
		test_ramps(20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd2, 1'b0, 60);
		test_ramps(20'd200000, 32'd6, 32'd1, 16'd2, 1'b1, 200);
		drain();
		$display("covered %0d result beats, %0d of them steps, over six ramp profiles",
			beats_seen, steps_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
